[hdl/dei_pkg.sv]
// Shared types and constants for the drive enable interlock.
`default_nettype none
package dei_pkg;

    localparam int IdW     = 29;
    localparam int TicksW  = 16;
    localparam int LenW    = 4;
    localparam int ByteW   = 8;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = 29;
    localparam int InDataW  = 48;
    localparam int OutDataW = 8;

    localparam logic [ByteW-1:0] BatteryOkCode = 8'h01;
    localparam logic [TicksW-1:0] BuzzerTicksReset = 16'd200;

    typedef enum logic [CfgIdxW-1:0] {
        REG_BATTERY_ID   = 2'd0,
        REG_BUZZER_TICKS = 2'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_OFF      = 3'd0,
        ST_LV_ON    = 3'd1,
        ST_HV_READY = 3'd3,
        ST_READY    = 3'd4,
        ST_DRIVE    = 3'd5,
        ST_FAULT    = 3'd6
    } veh_state_t;

    typedef struct packed {
        veh_state_t        state;
        veh_state_t        reported;
        logic              enable;
        logic              buzzer;
        logic [TicksW-1:0] remaining;
    } ilk_state_t;

    typedef struct packed {
        logic brake;
        logic button;
        logic loop_ok;
    } tick_t;

    typedef struct packed {
        veh_state_t state;
        logic       enable;
        logic       buzzer;
        logic       report_valid;
        logic       report_brake;
        logic       report_battery_ok;
    } result_t;

endpackage
`default_nettype wire

[hdl/drive_enable_interlock_fsm.sv]
// A tick's result is registered and appears on m_tdata in the cycle after it is accepted.
// Throughput: one item per cycle when not stalled; a frame gives no result, only updates battery OK.
// s_tready stays high while the single output register is empty or being taken.
// Reset (aresetn low, synchronous): state LV on, nothing reported yet,
// battery OK, enable and buzzer cleared; battery id 0, buzzer duration 200 ticks.
`default_nettype none
module drive_enable_interlock_fsm
    import dei_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [0] brake_pressed, [1] start_button, [2] shutdown_closed, [31:3] frame_id,
    // [35:32] frame_length, [43:36] frame_first_byte, [47:44] zero
    input  wire logic [InDataW-1:0]  s_tdata,
    // [0] req_type
    input  wire logic                s_tuser,

    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [2:0] vehicle_state, [3] drive_enable, [4] buzzer_on, [5] report_valid,
    // [6] report_brake, [7] report_battery_ok
    output logic [OutDataW-1:0]      m_tdata,

    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgW-1:0]     cfg_data
);

    ilk_state_t          st_reg, st_next;
    logic                battery_ok_reg;
    logic [IdW-1:0]      battery_id_reg;
    logic [TicksW-1:0]   buzzer_ticks_reg;
    logic                m_tvalid_reg;
    logic [OutDataW-1:0] m_tdata_reg;

    tick_t               tick;
    result_t             res;
    logic                in_accept;
    logic                is_frame;
    logic                frame_match;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;
    assign is_frame  = s_tuser;

    assign tick.brake   = s_tdata[0];
    assign tick.button  = s_tdata[1];
    assign tick.loop_ok = s_tdata[2];

    assign frame_match = (s_tdata[31:3] == battery_id_reg) && (s_tdata[35:32] != '0);

    dei_step u_step (
        .cur          (st_reg),
        .tick         (tick),
        .battery_ok   (battery_ok_reg),
        .buzzer_ticks (buzzer_ticks_reg),
        .nxt          (st_next),
        .res          (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.state     <= ST_LV_ON;
            st_reg.reported  <= ST_OFF;
            st_reg.enable    <= 1'b0;
            st_reg.buzzer    <= 1'b0;
            st_reg.remaining <= '0;
            battery_ok_reg   <= 1'b0;
            battery_id_reg   <= '0;
            buzzer_ticks_reg <= BuzzerTicksReset;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_BATTERY_ID:   battery_id_reg   <= cfg_data[IdW-1:0];
                    REG_BUZZER_TICKS: buzzer_ticks_reg <= cfg_data[TicksW-1:0];
                    default: ;
                endcase
            end

            if (in_accept && !is_frame) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (in_accept) begin
                if (is_frame) begin
                    if (frame_match) battery_ok_reg <= (s_tdata[43:36] == BatteryOkCode);
                end else begin
                    st_reg <= st_next;
                end
            end
        end

        // payload, no reset
        if (in_accept && !is_frame) begin
            m_tdata_reg <= {res.report_battery_ok, res.report_brake, res.report_valid,
                            res.buzzer, res.enable, res.state};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    a_enable_only_in_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.enable |-> st_reg.state == ST_DRIVE)
        else $error("enable set outside drive state");

    a_fault_latched: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.state == ST_FAULT |=> st_reg.state == ST_FAULT)
        else $error("fault state left without reset");

    a_reported_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.reported == ST_OFF || st_reg.reported == st_reg.state)
        else $error("reported state diverged from current state");

    a_tick_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && !is_frame |=> m_tvalid_reg)
        else $error("accepted tick produced no result");

    a_buzzer_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.remaining != '0 |-> st_reg.buzzer)
        else $error("buzzer off while timer running");
`endif

endmodule
`default_nettype wire

[hdl/dei_step.sv]
// Next-state logic for one tick: state transitions, enable, buzzer timer, report.
`default_nettype none
module dei_step
    import dei_pkg::*;
(
    input  ilk_state_t        cur,
    input  tick_t             tick,
    input  logic              battery_ok,
    input  logic [TicksW-1:0] buzzer_ticks,
    output ilk_state_t        nxt,
    output result_t           res
);

    veh_state_t        target;
    logic              started;
    logic              enable_v;
    logic              buzzer_v;
    logic [TicksW-1:0] remain_v;
    logic              report;

    always_comb begin
        target = cur.state;
        case (cur.state)
            ST_LV_ON: begin
                if (tick.loop_ok) target = ST_HV_READY;
            end
            ST_HV_READY: begin
                if (!tick.loop_ok) target = ST_LV_ON;
                else if (tick.brake && tick.button && battery_ok) target = ST_READY;
            end
            ST_READY: begin
                target = ST_DRIVE;
            end
            ST_DRIVE: begin
                if (!tick.loop_ok || !battery_ok) target = ST_FAULT;
            end
            default: begin
                target = cur.state;
            end
        endcase

        enable_v = cur.enable;
        buzzer_v = cur.buzzer;
        remain_v = cur.remaining;
        started  = 1'b0;
        if (cur.state == ST_FAULT) enable_v = 1'b0;

        if (target != cur.state) begin
            if (target == ST_READY) begin
                // buzzer (re)starts; zero duration gives no pulse
                remain_v = buzzer_ticks;
                buzzer_v = (buzzer_ticks != '0);
                started  = 1'b1;
            end else if (target == ST_DRIVE) begin
                enable_v = 1'b1;
            end else begin
                enable_v = 1'b0;
            end
        end

        if (!started && remain_v != '0) begin
            remain_v = remain_v - 1'b1;
            if (remain_v == '0) buzzer_v = 1'b0;
        end

        report = (target != cur.reported);

        nxt.state     = target;
        nxt.reported  = target;
        nxt.enable    = enable_v;
        nxt.buzzer    = buzzer_v;
        nxt.remaining = remain_v;

        res.state             = target;
        res.enable            = enable_v;
        res.buzzer            = buzzer_v;
        res.report_valid      = report;
        res.report_brake      = report & tick.brake;
        res.report_battery_ok = report & battery_ok;
    end

endmodule
`default_nettype wire
